FILE: hw/rtl/rle_escape_byte_decoder_defines.svh
// ----------------------------------------------------------------------------
// rle escape byte decoder assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef RLE_ESCAPE_BYTE_DECODER_DEFINES_SVH
`define RLE_ESCAPE_BYTE_DECODER_DEFINES_SVH

// checked outside reset
`define RLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define RLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rle_dec_pkg.sv
// ----------------------------------------------------------------------------
// rle decoder package
// widths, codes and the result record shared by the decoder files
// ----------------------------------------------------------------------------
package rle_dec_pkg;

    localparam int TOTAL_BITS_DEF = 24;
    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 16;
    localparam int CAP_W          = 24;
    localparam int OUT_TOTAL_W    = 24;
    localparam int Q_DEPTH        = 3;

    localparam logic [CAP_W-1:0]  CAP_RESET  = {CAP_W{1'b1}};
    localparam logic [BYTE_W-1:0] LONG_MARK  = 8'h80;
    localparam logic [BYTE_W-1:0] SHORT_MASK = 8'h7f;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_IDLE,
        PH_AFTER_ESC,
        PH_COUNT,
        PH_LOW,
        PH_DISCARD
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DONE,
        ST_OVERFLOW,
        ST_TRUNC
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0]      value;
        logic [LEN_W-1:0]       length;
        logic [OUT_TOTAL_W-1:0] total;
        t_status                status;
        logic                   fin;
    } t_result;

    // results caused by one packed byte: run item first, report second
    typedef struct packed {
        logic    vld_a;
        t_result a;
        logic    vld_b;
        t_result b;
    } t_step;

endpackage

FILE: hw/rtl/rle_dec_core.sv
// ----------------------------------------------------------------------------
// rle decoder core
// stream state, capacity register and per-byte result generation
// ----------------------------------------------------------------------------
module rle_dec_core import rle_dec_pkg::*; #(
    parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_packed_byte,
    input  logic              i_last_byte,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_data,
    output t_step             o_step
);

    localparam int SW = (TOTAL_BITS + 1 > CAP_W + 1) ? TOTAL_BITS + 1 : CAP_W + 1;

    t_phase                r_phase, n_phase;
    logic [BYTE_W-1:0]     r_esc, n_esc;
    logic [BYTE_W-1:0]     r_pend, n_pend;
    logic [BYTE_W-1:0]     r_high, n_high;
    logic [TOTAL_BITS-1:0] r_total, n_total;
    logic [CAP_W-1:0]      r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_esc   <= '0;
            r_pend  <= '0;
            r_high  <= '0;
            r_total <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_pend  <= n_pend;
            r_high  <= n_high;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    always_comb begin
        logic              run_req;
        logic [BYTE_W-1:0] run_val;
        logic [LEN_W-1:0]  run_len;
        logic [SW-1:0]     next_sum;
        logic [SW-1:0]     tot_ext;
        logic              emit;
        logic              ovf;
        logic              mid;

        n_phase = r_phase;
        n_esc   = r_esc;
        n_pend  = r_pend;
        n_high  = r_high;
        n_total = r_total;
        run_req = 1'b0;
        run_val = '0;
        run_len = '0;

        unique case (r_phase)
            PH_HEADER: begin
                n_esc   = i_packed_byte;
                n_phase = PH_IDLE;
            end
            PH_IDLE: begin
                if (i_packed_byte == r_esc) begin
                    n_phase = PH_AFTER_ESC;
                end else begin
                    run_req = 1'b1;
                    run_val = i_packed_byte;
                    run_len = LEN_W'(1);
                end
            end
            PH_AFTER_ESC: begin
                if (i_packed_byte == r_esc) begin
                    n_phase = PH_IDLE;
                    run_req = 1'b1;
                    run_val = r_esc;
                    run_len = LEN_W'(1);
                end else begin
                    n_pend  = i_packed_byte;
                    n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (i_packed_byte > LONG_MARK) begin
                    n_phase = PH_IDLE;
                    run_req = 1'b1;
                    run_val = r_pend;
                    run_len = LEN_W'(i_packed_byte & SHORT_MASK);
                end else begin
                    n_high  = i_packed_byte;
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                n_phase = PH_IDLE;
                run_req = 1'b1;
                run_val = r_pend;
                run_len = {r_high, i_packed_byte};
            end
            PH_DISCARD: begin
                n_phase = PH_DISCARD;
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        // capacity and total range check
        emit     = run_req && (run_len != '0);
        tot_ext  = SW'(r_total);
        next_sum = tot_ext + SW'(run_len);
        ovf      = emit && ((next_sum > SW'(r_cap)) || (next_sum[SW-1:TOTAL_BITS] != '0));

        if (ovf) begin
            n_phase = PH_DISCARD;
        end else if (emit) begin
            n_total = next_sum[TOTAL_BITS-1:0];
        end

        o_step.vld_a    = emit;
        o_step.a.value  = run_val;
        o_step.a.length = run_len;
        o_step.a.total  = ovf ? tot_ext[OUT_TOTAL_W-1:0] : next_sum[OUT_TOTAL_W-1:0];
        o_step.a.status = ovf ? ST_OVERFLOW : ST_RUN;

        // end of stream report
        mid = (n_phase == PH_AFTER_ESC) || (n_phase == PH_COUNT) || (n_phase == PH_LOW);
        tot_ext = SW'(n_total);
        o_step.vld_b    = i_last_byte && !ovf && (r_phase != PH_DISCARD);
        o_step.b.value  = '0;
        o_step.b.length = '0;
        o_step.b.total  = tot_ext[OUT_TOTAL_W-1:0];
        o_step.b.status = mid ? ST_TRUNC : ST_DONE;
        o_step.b.fin    = 1'b1;
        o_step.a.fin    = !o_step.vld_b;

        if (i_last_byte) begin
            n_phase = PH_HEADER;
            n_esc   = '0;
            n_pend  = '0;
            n_high  = '0;
            n_total = '0;
        end
    end

endmodule

FILE: hw/rtl/rle_dec_fifo.sv
// ----------------------------------------------------------------------------
// rle decoder result queue
// small queue taking up to two results per cycle, draining one when popped
// ----------------------------------------------------------------------------
module rle_dec_fifo import rle_dec_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_step   i_step,
    input  logic    i_pop,
    output logic    o_valid,
    output logic    o_full,
    output t_result o_head
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_result            r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               wr_a, wr_b;
    logic [PTR_W-1:0]   wr_b_ptr;
    logic [CNT_W-1:0]   push_n;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_a     = i_push && i_step.vld_a;
    assign wr_b     = i_push && i_step.vld_b;
    assign wr_b_ptr = wr_a ? ptr_inc(r_wr) : r_wr;
    assign push_n   = CNT_W'(wr_a) + CNT_W'(wr_b);

    always_comb begin
        n_rd  = (i_pop && o_valid) ? ptr_inc(r_rd) : r_rd;
        n_wr  = wr_b ? ptr_inc(wr_b_ptr) : (wr_a ? ptr_inc(r_wr) : r_wr);
        n_cnt = r_cnt + push_n - CNT_W'(i_pop && o_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_mem[r_wr] <= i_step.a;
        end
        if (wr_b) begin
            r_mem[wr_b_ptr] <= i_step.b;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt >= CNT_W'(Q_DEPTH - 1));
    assign o_head  = r_mem[r_rd];

endmodule

FILE: hw/rtl/rle_escape_byte_decoder.sv
// ----------------------------------------------------------------------------
// rle escape byte decoder
// unpacks an escape-coded run-length stream into runs and stream reports
// ----------------------------------------------------------------------------
//  port group  direction  handshake            payload
//  in          request    i_in_valid/o_in_stall    packed byte, last flag
//  out         result     o_out_valid/i_out_stall  value, length, total, status, final
//  cfg         write      i_cfg_valid/o_cfg_ready  output capacity
//
//  one packed byte per cycle while o_in_stall is low; a byte giving a run and a report yields two results
//  stall on the input comes from the fill of the three-entry result queue
//  an accepted request's results are registered in the result queue before they appear on the output
//  synchronous active-low reset; capacity resets to all ones
// ----------------------------------------------------------------------------
module rle_escape_byte_decoder import rle_dec_pkg::*; #(
    parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [BYTE_W-1:0]      i_packed_byte,
    input  logic                   i_last_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [BYTE_W-1:0]      o_run_value,
    output logic [LEN_W-1:0]       o_run_length,
    output logic [OUT_TOTAL_W-1:0] o_total_length,
    output logic [1:0]             o_status,
    output logic                   o_final_of_step,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CAP_W-1:0]       i_cfg_data
);

    logic    accept;
    logic    full;
    t_step   step;
    t_result head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;

    rle_dec_core #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_packed_byte (i_packed_byte),
        .i_last_byte   (i_last_byte),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_step        (step)
    );

    rle_dec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_step  (step),
        .i_pop   (!i_out_stall),
        .o_valid (o_out_valid),
        .o_full  (full),
        .o_head  (head)
    );

    assign o_run_value     = head.value;
    assign o_run_length    = head.length;
    assign o_total_length  = head.total;
    assign o_status        = head.status;
    assign o_final_of_step = head.fin;

endmodule

FILE: hw/rtl/rle_dec_chk.sv
// ----------------------------------------------------------------------------
// rle decoder port checker
// port-level properties of the decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "rle_escape_byte_decoder_defines.svh"

module rle_dec_chk import rle_dec_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [BYTE_W-1:0]      o_run_value,
    input logic [LEN_W-1:0]       o_run_length,
    input logic [OUT_TOTAL_W-1:0] o_total_length,
    input logic [1:0]             o_status,
    input logic                   o_final_of_step
);

    logic report;
    assign report = (o_status == ST_DONE) || (o_status == ST_TRUNC);

    `RLE_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_run_value) &&
        $stable(o_run_length) && $stable(o_total_length) && $stable(o_status) &&
        $stable(o_final_of_step), "stalled result changed")
    `RLE_ASSERT(a_report_empty, i_clk, i_rst_n,
        o_out_valid && report |-> (o_run_value == '0) && (o_run_length == '0),
        "report carries run data")
    `RLE_ASSERT(a_nonrun_final, i_clk, i_rst_n,
        o_out_valid && (o_status != ST_RUN) |-> o_final_of_step,
        "report or overflow not final")
    `RLE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid,
        "result valid after reset")

endmodule

bind rle_escape_byte_decoder rle_dec_chk u_chk (.*);
